// ----- src/clhpm_pkg.sv -----
// Shared types and constants for the cross-layer hit pair matcher.
// No dependencies; imported by every module of the block.
package clhpm_pkg;

   localparam int CHARGE_BITS  = 16;
   localparam int ASYM_W       = 16;
   localparam int MAX_HITS_W   = 7;
   localparam int HIT_COUNT_W  = 10;
   localparam int POINT_IDX_W  = 11;
   localparam int HIT_IDX_W    = 6;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   localparam int MIN_HITS = 2;

   localparam logic [ASYM_W-1:0]     MAX_ASYM_RESET = 16'd6554;
   localparam logic [MAX_HITS_W-1:0] MAX_HITS_RESET = 7'd40;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ASYM = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HITS = 1'b1;

   typedef struct packed {
      logic [2:0]             disc;
      logic                   first_in_disc;
      logic [HIT_COUNT_W-1:0] disc_hit_count;
      logic                   layer;
      logic [1:0]             quadrant;
      logic [CHARGE_BITS-1:0] charge;
   } req_type;

   typedef struct packed {
      logic [2:0]             point_disc;
      logic [POINT_IDX_W-1:0] point_index;
      logic [HIT_IDX_W-1:0]   new_hit_index;
      logic [HIT_IDX_W-1:0]   old_hit_index;
      logic                   last_of_run;
   } rsp_type;

   typedef struct packed {
      logic                   layer;
      logic [1:0]             quadrant;
      logic [CHARGE_BITS-1:0] charge;
   } hit_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // take the request, clear on first-in-disc
      logic issue;   // read next stored hit
      logic finish;  // flush held point, store the hit
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit_ok;
      logic scan_done;
      logic pipe_idle;
   } status_type;

endpackage

// ----- src/clhpm_ctrl.sv -----
// Sequencer for the hit pair matcher: load, scan of the store, drain, finish.
// Depends on clhpm_pkg (command and status structs).
module clhpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  clhpm_pkg::status_type  status,
   output clhpm_pkg::cmd_type     cmd
);
   import clhpm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (status.hit_ok) state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_DRAIN;
            else cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            if (status.pipe_idle) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   a_no_issue_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_done) |-> !cmd.issue)
      else $error("issue after scan end");
   a_finish_ends_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("still busy after finish");
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("load while busy");

endmodule

// ----- src/clhpm_dp.sv -----
// Datapath of the hit pair matcher: hit store, scan pipeline, asymmetry test,
// held point for end-of-run marking, counters and config registers. Uses clhpm_pkg.
module clhpm_dp #(
   parameter int HIT_STORE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  clhpm_pkg::req_type                   req_data,
   input  logic                                 csr_we,
   input  logic [clhpm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [clhpm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  clhpm_pkg::cmd_type                   cmd,
   output clhpm_pkg::status_type                status,
   output logic                                 rsp_valid,
   output clhpm_pkg::rsp_type                   rsp_data
);
   import clhpm_pkg::*;

   localparam int ADDR_W = $clog2(HIT_STORE_DEPTH);
   localparam int CNT_W  = $clog2(HIT_STORE_DEPTH + 1);
   localparam int SUM_W  = CHARGE_BITS + 1;
   localparam int PROD_W = ASYM_W + SUM_W;

   hit_entry_type mem [HIT_STORE_DEPTH];

   logic [ASYM_W-1:0]      max_asym_ff, max_asym_in;
   logic [MAX_HITS_W-1:0]  max_hits_ff, max_hits_in;
   logic [CNT_W-1:0]       stored_count_ff, stored_count_in;
   logic [CNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [POINT_IDX_W-1:0] point_counter_ff, point_counter_in;

   logic [2:0]             cur_disc_ff, cur_disc_in;
   logic [HIT_IDX_W-1:0]   cur_idx_ff, cur_idx_in;
   hit_entry_type          cur_hit_ff, cur_hit_in;

   hit_entry_type          rd_data_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]      s1_idx_ff, s1_idx_in;

   logic                   s2_valid_ff, s2_valid_in;
   logic [CHARGE_BITS-1:0] s2_diff_ff, s2_diff_in;
   logic [SUM_W-1:0]       s2_sum_ff, s2_sum_in;
   logic [ADDR_W-1:0]      s2_idx_ff, s2_idx_in;

   logic                   pend_valid_ff, pend_valid_in;
   rsp_type                pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [CNT_W-1:0]       eff_count;
   logic [PROD_W-1:0]      prod;
   logic [PROD_W-1:0]      lhs;
   logic                   match;

   // store occupancy as seen by this request (first-in-disc empties it)
   assign eff_count = req_data.first_in_disc ? '0 : stored_count_ff;

   assign status.hit_ok =
      (req_data.disc_hit_count >= HIT_COUNT_W'(MIN_HITS)) &&
      (req_data.disc_hit_count <= HIT_COUNT_W'(max_hits_ff)) &&
      (eff_count < CNT_W'(HIT_STORE_DEPTH));
   assign status.scan_done = (scan_idx_ff == stored_count_ff);
   assign status.pipe_idle = !s1_valid_ff && !s2_valid_ff;

   // |q1-q2| << 16 <= max_asym * (q1+q2)
   assign prod  = PROD_W'(max_asym_ff) * PROD_W'(s2_sum_ff);
   assign lhs   = PROD_W'({s2_diff_ff, {ASYM_W{1'b0}}});
   assign match = s2_valid_ff && (lhs <= prod);

   always_comb begin
      max_asym_in      = max_asym_ff;
      max_hits_in      = max_hits_ff;
      stored_count_in  = stored_count_ff;
      scan_idx_in      = scan_idx_ff;
      point_counter_in = point_counter_ff;
      cur_disc_in      = cur_disc_ff;
      cur_idx_in       = cur_idx_ff;
      cur_hit_in       = cur_hit_ff;
      pend_valid_in    = pend_valid_ff;
      pend_in          = pend_ff;
      rsp_valid_in     = 1'b0;
      rsp_in           = rsp_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_ASYM: max_asym_in = csr_wdata[ASYM_W-1:0];
            CSR_MAX_HITS: max_hits_in = csr_wdata[MAX_HITS_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         if (req_data.first_in_disc) begin
            stored_count_in  = '0;
            point_counter_in = '0;
         end
         scan_idx_in         = '0;
         pend_valid_in       = 1'b0;
         cur_disc_in         = req_data.disc;
         cur_idx_in          = HIT_IDX_W'(eff_count);
         cur_hit_in.layer    = req_data.layer;
         cur_hit_in.quadrant = req_data.quadrant;
         cur_hit_in.charge   = req_data.charge;
      end

      if (cmd.issue) scan_idx_in = scan_idx_ff + CNT_W'(1);

      // a point is held one match back so the final one can be marked
      if (match) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
         end
         pend_valid_in         = 1'b1;
         pend_in.point_disc    = cur_disc_ff;
         pend_in.point_index   = point_counter_ff;
         pend_in.new_hit_index = cur_idx_ff;
         pend_in.old_hit_index = HIT_IDX_W'(s2_idx_ff);
         pend_in.last_of_run   = 1'b0;
         point_counter_in      = point_counter_ff + POINT_IDX_W'(1);
      end

      if (cmd.finish) begin
         if (pend_valid_ff) begin
            rsp_valid_in       = 1'b1;
            rsp_in             = pend_ff;
            rsp_in.last_of_run = 1'b1;
         end
         pend_valid_in   = 1'b0;
         stored_count_in = stored_count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      s1_valid_in = cmd.issue;
      s1_idx_in   = scan_idx_ff[ADDR_W-1:0];
      s2_valid_in = s1_valid_ff && (rd_data_ff.layer != cur_hit_ff.layer) &&
                    (rd_data_ff.quadrant == cur_hit_ff.quadrant);
      s2_diff_in  = (cur_hit_ff.charge >= rd_data_ff.charge) ?
                    (cur_hit_ff.charge - rd_data_ff.charge) :
                    (rd_data_ff.charge - cur_hit_ff.charge);
      s2_sum_in   = SUM_W'(cur_hit_ff.charge) + SUM_W'(rd_data_ff.charge);
      s2_idx_in   = s1_idx_ff;
   end

   // hit store: one read port for the scan, one write at finish
   always_ff @(posedge clock) begin
      if (cmd.finish) mem[stored_count_ff[ADDR_W-1:0]] <= cur_hit_ff;
      rd_data_ff <= mem[scan_idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_asym_ff      <= MAX_ASYM_RESET;
         max_hits_ff      <= MAX_HITS_RESET;
         stored_count_ff  <= '0;
         scan_idx_ff      <= '0;
         point_counter_ff <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         max_asym_ff      <= max_asym_in;
         max_hits_ff      <= max_hits_in;
         stored_count_ff  <= stored_count_in;
         scan_idx_ff      <= scan_idx_in;
         point_counter_ff <= point_counter_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         pend_valid_ff    <= pend_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_disc_ff <= cur_disc_in;
      cur_idx_ff  <= cur_idx_in;
      cur_hit_ff  <= cur_hit_in;
      s1_idx_ff   <= s1_idx_in;
      s2_diff_ff  <= s2_diff_in;
      s2_sum_ff   <= s2_sum_in;
      s2_idx_ff   <= s2_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_finish_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!s1_valid_ff && !s2_valid_ff && !match))
      else $error("finish with compares in flight");
   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      stored_count_ff <= CNT_W'(HIT_STORE_DEPTH))
      else $error("hit store overfilled");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_idx_ff <= stored_count_ff || $past(cmd.load))
      else $error("scan ran past stored hits");
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_of_run) |=> !rsp_valid_ff)
      else $error("point right after end of run");

endmodule

// ----- src/cross_layer_hit_pair_matcher.sv -----
// Cross-layer hit pair matcher, top level.
// Instantiates clhpm_ctrl and clhpm_dp; types from clhpm_pkg.
//
// Usage:
//   A hit request is taken at a clock edge with start high and busy low.
//   Hits come grouped by disc; first_in_disc empties the hit store and
//   restarts the point numbering. A hit whose disc hit count is below 2 or
//   above max_hits, or that finds the store full, is dropped and busy never
//   rises.
//   An accepted hit is compared with the N hits already stored for its disc,
//   one per cycle, then appended. busy stays high through the scan and the
//   drain of the compare pipeline; the drain is longer when the newest stored
//   hit is in the other layer and the same quadrant. N is at most 63 with a
//   64-entry store; the hit store has a single read port for the scan.
//   Each matching pair gives one point on rsp_data with rsp_valid high for
//   one cycle; the last point of a hit carries last_of_run. The receiver
//   cannot stall the points.
//   Config writes (csr_we/csr_index/csr_wdata) are registered; they are to be
//   made while busy is low, which the block does not enforce. Reset clears
//   the store, the counters and sets max_asymmetry to 6554 and max_hits to 40.
module cross_layer_hit_pair_matcher #(
   parameter int HIT_STORE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  clhpm_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   output clhpm_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [clhpm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [clhpm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import clhpm_pkg::*;

   cmd_type    cmd;
   status_type status;

   clhpm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   clhpm_dp #(
      .HIT_STORE_DEPTH (HIT_STORE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
